// File: rtl/core/assert_macros.svh
// Assertion macros shared by the console RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/core/txc_pkg.sv
// Package for the text console writer: geometry, codes, state and address helper.
// Used by the top level; depends on nothing.
`default_nettype none
package txc_pkg;
  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int KEEP = CELLS - COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;

  localparam int COL_W = 7;
  localparam int ROW_W = 5;
  localparam int CHAR_W = 8;
  localparam int COLOUR_W = 4;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_INDEX_W = 2;

  localparam int IN_BITS = CHAR_W + COL_W + ROW_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_USER_W = 2;
  localparam int OUT_BITS = COL_W + ROW_W + 2 * CHAR_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W = 1;

  localparam logic [CHAR_W-1:0] CH_BS = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam int TAB_STEP = 4;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_SET  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TEXT_COLOUR = 2'd0,
    CFG_BACK_COLOUR = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(r) * ADDR_W'(COLUMNS);
    return base + ADDR_W'(c);
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/txc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
`default_nettype none
module txc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/text_console_char_writer_unit.sv
// Top level of the text console writer: command decode, cursor, scroll sequencer.
// Depends on txc_pkg, txc_ram and assert_macros.svh.
// Path from accept to output register: set cursor and plain put go through DONE, read through READ
// then DONE, a put that scrolls through SCROLL (copy of KEEP cells), FILL (a blank bottom row), DONE.
// Input: a new word is taken only in IDLE; DONE waits while the output register still holds an unaccepted word.
// Reset: synchronous; a clearing pass over all CELLS (2000) cells zeroes the store before input.
`default_nettype none
`include "assert_macros.svh"
module text_console_char_writer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // char_code [7:0], col [14:8], row [19:15], zero pad above.
  input  wire logic [txc_pkg::IN_DATA_W-1:0]   s_tdata,
  // command [1:0].
  input  wire logic [txc_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // cursor_x [6:0], cursor_y [11:7], cell_char [19:12], cell_attr [27:20], zero pad.
  output logic      [txc_pkg::OUT_DATA_W-1:0]  m_tdata,
  // scrolled [0].
  output logic      [txc_pkg::OUT_USER_W-1:0]  m_tuser,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [txc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [txc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import txc_pkg::*;

  state_t state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [COLOUR_W-1:0] text_colour, back_colour;
  logic [CELL_W-1:0] res_cell;
  logic res_scrolled;

  logic accept, load_out;
  cmd_t cmd;
  logic [CHAR_W-1:0] in_char;
  logic [COL_W-1:0] in_col, clamp_col;
  logic [ROW_W-1:0] in_row, clamp_row;
  logic [CHAR_W-1:0] attr;

  logic [COL_W:0] col_sum;
  logic [COL_W-1:0] put_col;
  logic [ROW_W-1:0] put_row;
  logic row_adv, put_scroll, put_we;
  logic [ADDR_W-1:0] put_addr;
  logic [CELL_W-1:0] put_wdata;

  logic ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign cmd = cmd_t'(s_tuser[1:0]);
  assign in_char = s_tdata[CHAR_W-1:0];
  assign in_col = s_tdata[CHAR_W +: COL_W];
  assign in_row = s_tdata[CHAR_W+COL_W +: ROW_W];
  assign clamp_col = (in_col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : in_col;
  assign clamp_row = (in_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : in_row;
  assign attr = {back_colour, text_colour};
  assign s_tready = (state == ST_IDLE);
  assign accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    col_sum = {1'b0, cur_col} + ((in_char == CH_TAB) ? (COL_W + 1)'(TAB_STEP)
                                                     : (COL_W + 1)'(1));
    put_col = cur_col;
    put_row = cur_row;
    row_adv = 1'b0;
    put_we = 1'b0;
    put_addr = cell_addr(cur_row, cur_col);
    put_wdata = {attr, in_char};
    case (in_char)
      CH_LF: begin
        put_col = '0;
        row_adv = 1'b1;
      end
      CH_CR: begin
        put_col = '0;
      end
      CH_BS: begin
        put_we = 1'b1;
        if (cur_col != '0) begin
          put_col = cur_col - COL_W'(1);
        end else if (cur_row != '0) begin
          put_col = COL_W'(COLUMNS - 1);
          put_row = cur_row - ROW_W'(1);
        end
        put_addr = cell_addr(put_row, put_col);
        put_wdata = {attr, CH_SPACE};
      end
      default: begin
        put_we = (in_char != CH_TAB);
        if (col_sum >= (COL_W + 1)'(COLUMNS)) begin
          put_col = COL_W'(col_sum - (COL_W + 1)'(COLUMNS));
          row_adv = 1'b1;
        end else begin
          put_col = col_sum[COL_W-1:0];
        end
      end
    endcase
    put_scroll = row_adv && (cur_row == ROW_W'(ROWS - 1));
    if (row_adv && !put_scroll) begin
      put_row = cur_row + ROW_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cnt == ADDR_W'(CELLS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_PUT: state_next = put_scroll ? ST_SCROLL : ST_DONE;
            CMD_READ: state_next = ST_READ;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_SCROLL: begin
        if (cnt == ADDR_W'(KEEP)) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (cnt == ADDR_W'(CELLS - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = cnt;
    ram_wdata = '0;
    ram_re = 1'b0;
    ram_raddr = cnt + ADDR_W'(COLUMNS);
    cnt_next = cnt;
    load_out = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        cnt_next = cnt + ADDR_W'(1);
      end
      ST_IDLE: begin
        cnt_next = '0;
        if (accept && cmd == CMD_PUT) begin
          ram_we = put_we;
          ram_waddr = put_addr;
          ram_wdata = put_wdata;
        end
        if (accept && cmd == CMD_READ) begin
          ram_re = 1'b1;
          ram_raddr = cell_addr(clamp_row, clamp_col);
        end
      end
      ST_SCROLL: begin
        ram_re = (cnt < ADDR_W'(KEEP));
        ram_we = (cnt != '0);
        ram_waddr = cnt - ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (cnt != ADDR_W'(KEEP)) cnt_next = cnt + ADDR_W'(1);
      end
      ST_FILL: begin
        ram_we = 1'b1;
        ram_wdata = BLANK_CELL;
        cnt_next = cnt + ADDR_W'(1);
      end
      ST_DONE: begin
        load_out = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt <= '0;
      cur_col <= '0;
      cur_row <= '0;
      text_colour <= COLOUR_W'(2);
      back_colour <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_TEXT_COLOUR: text_colour <= cfg_data[COLOUR_W-1:0];
          CFG_BACK_COLOUR: back_colour <= cfg_data[COLOUR_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept && cmd == CMD_PUT) begin
        cur_col <= put_col;
        cur_row <= put_row;
      end else if (accept && cmd == CMD_SET) begin
        cur_col <= clamp_col;
        cur_row <= clamp_row;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_cell <= '0;
      res_scrolled <= (cmd == CMD_PUT) && put_scroll;
    end else if (state == ST_READ) begin
      res_cell <= ram_rdata;
    end
    if (load_out) begin
      m_tdata <= {(OUT_DATA_W - OUT_BITS)'(0), res_cell, cur_row, cur_col};
      m_tuser <= res_scrolled;
    end
  end

  txc_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  `ASSERT_RST(a_cursor_range, clk, rst, (cur_col < COL_W'(COLUMNS)) && (cur_row < ROW_W'(ROWS)))
  `ASSERT_RST(a_no_rw_collide, clk, rst, (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
  `ASSERT_RST(a_idle_write, clk, rst, (state == ST_IDLE && ram_we) |-> (accept && cmd == CMD_PUT))
  `ASSERT_RST(a_out_from_done, clk, rst, $rose(m_tvalid) |-> ($past(state) == ST_DONE))
  `ASSERT_RST(a_fill_bottom, clk, rst, (state == ST_FILL) |-> (cur_row == ROW_W'(ROWS - 1)))
endmodule
`default_nettype wire
